@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used in the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the same cycle, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, checked through reset as well
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/cwdi_pkg.sv @@
// ----------------------------------------------------------------------------
// cwdi_pkg
// Shared constants, types and config decode for the central window
// downsample and invert core.
// ----------------------------------------------------------------------------
package cwdi_pkg;

    // Sizing
    localparam int MAX_OUT_WIDTH     = 1024;
    localparam int MAX_SCALE_QUARTER = 16;
    localparam int HEIGHT_MAX        = 1024;

    localparam int COL_W  = $clog2(MAX_OUT_WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT_MAX);
    localparam int SUB_W  = $clog2(4 * MAX_SCALE_QUARTER);
    localparam int Q_W    = 5;
    localparam int SIZE_W = 11;
    localparam int PIX_W  = 8;
    localparam int POS_W  = 10;
    localparam int SUM_W  = 18;
    localparam int DIV_W  = $clog2(4 * MAX_SCALE_QUARTER * MAX_SCALE_QUARTER) + 1;
    localparam int CNT_W  = $clog2(SUM_W + 1);

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_FLD_W   = PIX_W + 2 * POS_W;
    localparam int M_TDATA_W = ((M_FLD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FLD_W;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Config port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_QUARTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT    = 2'd2;

    localparam logic [Q_W-1:0]    RST_SCALE_QUARTER = 5'd2;
    localparam logic [SIZE_W-1:0] RST_OUT_WIDTH     = 11'd64;
    localparam logic [SIZE_W-1:0] RST_OUT_HEIGHT    = 11'd64;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Decoded configuration
    typedef struct packed {
        logic [Q_W-1:0]   q;
        logic [COL_W-1:0] w_last;
        logic [ROW_W-1:0] h_last;
    } cfg_t;

    // One in-window pixel handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] green;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             first;
        logic             last;
        logic             frame_last;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    // Clamp the raw registers: zero reads as one, large values saturate
    function automatic cfg_t cfg_decode(logic [Q_W-1:0] sq, logic [SIZE_W-1:0] ow,
                                        logic [SIZE_W-1:0] oh);
        cfg_t c;
        int   qv;
        int   wv;
        int   hv;
        qv = (sq == '0) ? 1 : ((int'(sq) > MAX_SCALE_QUARTER) ? MAX_SCALE_QUARTER : int'(sq));
        wv = (ow == '0) ? 1 : ((int'(ow) > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : int'(ow));
        hv = (oh == '0) ? 1 : ((int'(oh) > HEIGHT_MAX) ? HEIGHT_MAX : int'(oh));
        c.q      = Q_W'(qv);
        c.w_last = COL_W'(wv - 1);
        c.h_last = ROW_W'(hv - 1);
        return c;
    endfunction

endpackage

@@ hw/rtl/cwdi_front.sv @@
// ----------------------------------------------------------------------------
// cwdi_front
// Raster position tracking and window classification; forwards only pixels
// inside the central window of their block.
// ----------------------------------------------------------------------------
module cwdi_front import cwdi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // [7:0] green_value
    input  logic                 q_full,
    output logic                 q_push,
    output item_t                q_item
);

    logic [COL_W-1:0] block_column_reg, block_column_next;
    logic [SUB_W-1:0] sub_column_reg, sub_column_next;
    logic [ROW_W-1:0] block_row_reg, block_row_next;
    logic [SUB_W-1:0] sub_row_reg, sub_row_next;

    logic [SUB_W-1:0] lo, hi, hi_m1, scale_m1;
    logic             in_col, in_row, accept;

    // Window bounds from the scale
    assign lo       = SUB_W'(cfg.q);
    assign hi       = SUB_W'({cfg.q, 1'b0}) + lo;
    assign hi_m1    = hi - SUB_W'(1);
    assign scale_m1 = SUB_W'({1'b0, cfg.q, 2'b00} - (Q_W + 3)'(1));

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign in_col = (sub_column_reg >= lo) && (sub_column_reg < hi);
    assign in_row = (sub_row_reg >= lo) && (sub_row_reg < hi);

    // Classification of the current pixel
    always_comb begin
        q_push            = accept && in_col && in_row;
        q_item.green      = s_tdata[PIX_W-1:0];
        q_item.col        = block_column_reg;
        q_item.row        = block_row_reg;
        q_item.first      = (sub_row_reg == lo) && (sub_column_reg == lo);
        q_item.last       = (sub_row_reg == hi_m1) && (sub_column_reg == hi_m1);
        q_item.frame_last = (block_column_reg >= cfg.w_last) && (block_row_reg >= cfg.h_last);
    end

    // Raster counter advance, each wrapping at its limit
    always_comb begin
        block_column_next = block_column_reg;
        sub_column_next   = sub_column_reg;
        block_row_next    = block_row_reg;
        sub_row_next      = sub_row_reg;
        if (accept) begin
            if (sub_column_reg >= scale_m1) begin
                sub_column_next = '0;
                if (block_column_reg >= cfg.w_last) begin
                    block_column_next = '0;
                    if (sub_row_reg >= scale_m1) begin
                        sub_row_next = '0;
                        if (block_row_reg >= cfg.h_last) begin
                            block_row_next = '0;
                        end else begin
                            block_row_next = block_row_reg + ROW_W'(1);
                        end
                    end else begin
                        sub_row_next = sub_row_reg + SUB_W'(1);
                    end
                end else begin
                    block_column_next = block_column_reg + COL_W'(1);
                end
            end else begin
                sub_column_next = sub_column_reg + SUB_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_column_reg <= '0;
            sub_column_reg   <= '0;
            block_row_reg    <= '0;
            sub_row_reg      <= '0;
        end else begin
            block_column_reg <= block_column_next;
            sub_column_reg   <= sub_column_next;
            block_row_reg    <= block_row_next;
            sub_row_reg      <= sub_row_next;
        end
    end

endmodule

@@ hw/rtl/cwdi_fifo.sv @@
// ----------------------------------------------------------------------------
// cwdi_fifo
// Small register queue between the front and back of the core.
// ----------------------------------------------------------------------------
module cwdi_fifo import cwdi_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/cwdi_div.sv @@
// ----------------------------------------------------------------------------
// cwdi_div
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module cwdi_div import cwdi_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W-1:0] shifted;
    logic             fits;

    // One shift-subtract step; remainder stays below the divisor
    assign shifted = {rem_reg[DIV_W-2:0], quo_reg[SUM_W-1]};
    assign fits    = (shifted >= dvs_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? shifted - dvs_reg : shifted;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ hw/rtl/cwdi_back.sv @@
// ----------------------------------------------------------------------------
// cwdi_back
// Column sum line store, read-modify-write per window pixel, mean and
// inversion on the last pixel of a window, and the result register.
// ----------------------------------------------------------------------------
module cwdi_back import cwdi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_empty,
    input  item_t                q_head,
    output logic                 q_pop,
    output div_req_t             div_req,
    input  div_rsp_t             div_rsp,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // [7:0] pixel_value, [17:8] pixel_x,
                                              // [27:18] pixel_y, rest zero
    output logic                 m_tlast      // frame_last
);

    bk_state_t state_reg, state_next;

    // Line store
    logic [SUM_W-1:0] col_sum_mem [MAX_OUT_WIDTH];
    logic [SUM_W-1:0] rd_data_reg;
    logic             rd_en, wr_en;

    item_t            item_reg;
    logic [SUM_W:0]   add_wide;
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] mean;
    logic [DIV_W-3:0] q_sq;
    logic             out_free, out_load;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // Accumulate with saturation; the first window pixel starts a new sum
    assign add_wide = {1'b0, rd_data_reg} + (SUM_W + 1)'(item_reg.green);
    assign sum      = item_reg.first ? SUM_W'(item_reg.green)
                    : (add_wide[SUM_W] ? SUM_MAX : add_wide[SUM_W-1:0]);

    // Window area is 4 * q * q
    assign q_sq = (DIV_W - 2)'(cfg.q) * (DIV_W - 2)'(cfg.q);

    // Mean saturates at full scale
    assign mean = (|div_rsp.quotient[SUM_W-1:PIX_W]) ? PIX_MAX
                : div_rsp.quotient[PIX_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_ACC;
            BK_ACC:  state_next = item_reg.last ? BK_DIV : BK_IDLE;
            BK_DIV:  if (div_rsp.done) state_next = BK_OUT;
            BK_OUT:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        out_load = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum;
        div_req.divisor  = {q_sq, 2'b00};
        case (state_reg)
            BK_IDLE: begin
                q_pop = !q_empty;
                rd_en = !q_empty;
            end
            BK_ACC: begin
                wr_en         = 1'b1;
                div_req.start = item_reg.last;
            end
            BK_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item latch
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_head;
        end
    end

    // Line store access, read data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= col_sum_mem[q_head.col];
        end
        if (wr_en) begin
            col_sum_mem[item_reg.col] <= sum;
        end
    end

    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, POS_W'(item_reg.row), POS_W'(item_reg.col),
                            PIX_MAX - mean};
            m_tlast_reg <= item_reg.frame_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hw/rtl/central_window_downsample_invert_core.sv @@
// A window's last pixel passes the queue, the line store read-modify-write, the mean divider
//   and the result register. Pixels are accepted one per cycle while the queue is not full;
//   the back end pops a window pixel only once the last is through, and the last pixel of a
//   window also waits for the 18-step mean divider. A 4-entry queue absorbs the difference.
// Reset: synchronous, active low; clears counters, queue and control, loads config defaults.
//   The column sum store is not cleared; each window overwrites its entry first.
// ----------------------------------------------------------------------------
// central_window_downsample_invert_core
// Central-window box downsample of a green channel stream with inverted mean.
// ----------------------------------------------------------------------------
module central_window_downsample_invert_core import cwdi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // [7:0] green_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // [7:0] pixel_value, [17:8] pixel_x,
                                              // [27:18] pixel_y, [31:28] zero
    output logic                 m_tlast      // frame_last
);

    logic [Q_W-1:0]    scale_quarter_reg;
    logic [SIZE_W-1:0] out_width_reg;
    logic [SIZE_W-1:0] out_height_reg;
    cfg_t              cfg;

    logic     q_push, q_full, q_pop, q_empty;
    item_t    q_in, q_head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_quarter_reg <= RST_SCALE_QUARTER;
            out_width_reg     <= RST_OUT_WIDTH;
            out_height_reg    <= RST_OUT_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SCALE_QUARTER: scale_quarter_reg <= cfg_wdata[Q_W-1:0];
                CFG_OUT_WIDTH:     out_width_reg     <= cfg_wdata;
                CFG_OUT_HEIGHT:    out_height_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_decode(scale_quarter_reg, out_width_reg, out_height_reg);

    cwdi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    cwdi_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    cwdi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    cwdi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/cwdi_checker.sv @@
// ----------------------------------------------------------------------------
// cwdi_checker
// Port-level checks on the result channel of the core, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cwdi_checker import cwdi_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // Stalled result stays offered and unchanged
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // Reset empties the result register
    `ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_tvalid)

    // Padding above the packed fields is zero
    `ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:M_FLD_W] == '0)

endmodule

bind central_window_downsample_invert_core cwdi_checker u_cwdi_checker (.*);
